// ===== rtl/core/rpg3d_pkg.sv =====
`timescale 1ns / 1ps

package rpg3d_pkg;

    localparam int SAMPLES_DEF    = 64;
    localparam int MAX_POINTS_DEF = 65536;

    localparam int COORD_W = 24;
    localparam int LEN_W   = 23;
    localparam int TRIG_W  = 16;
    localparam int CFG_W   = 24;
    localparam int REG_W   = 3;
    localparam int SLOT_W  = 6;
    localparam int IDX_W   = 16;
    localparam int KIND_W  = 2;

    // register indexes
    localparam logic [REG_W-1:0] REG_CENTER_X = 3'd0;
    localparam logic [REG_W-1:0] REG_BOTTOM_Y = 3'd1;
    localparam logic [REG_W-1:0] REG_CENTER_Z = 3'd2;
    localparam logic [REG_W-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [REG_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [REG_W-1:0] REG_LENGTH   = 3'd5;
    localparam logic [REG_W-1:0] REG_COS      = 3'd6;
    localparam logic [REG_W-1:0] REG_SIN      = 3'd7;

    localparam logic signed [TRIG_W-1:0] COS_RESET = 16'sd16384;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_CAPTURED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FILL     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY    = 2'd2;

    // coarse window, 10.0 in Q12.12
    localparam logic signed [COORD_W:0] WINDOW = 25'sd40960;

    typedef struct packed {
        logic load_point;
        logic capture;
        logic emit_empty;
        logic fill_start;
        logic fill_adv;
        logic clr_box;
    } t_cmd;

    typedef struct packed {
        logic pt_hit;
        logic cap_full;
        logic cap_zero;
        logic point_last;
        logic fill_end;
        logic out_free;
    } t_status;

endpackage

// ===== rtl/core/rpg3d_ram.sv =====
`timescale 1ns / 1ps

module rpg3d_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/rpg3d_ctrl.sv =====
`timescale 1ns / 1ps

module rpg3d_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  rpg3d_pkg::t_status i_status,
    output rpg3d_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIFF = 3'd1;
    localparam logic [2:0] ST_MUL  = 3'd2;
    localparam logic [2:0] ST_CHK  = 3'd3;
    localparam logic [2:0] ST_DEC  = 3'd4;
    localparam logic [2:0] ST_END  = 3'd5;
    localparam logic [2:0] ST_FILL = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_point = 1'b1;
                    n_state          = ST_DIFF;
                end
            end
            ST_DIFF: n_state = ST_MUL;
            ST_MUL:  n_state = ST_CHK;
            ST_CHK:  n_state = ST_DEC;
            ST_DEC: begin
                if (i_status.pt_hit && !i_status.cap_full) begin
                    if (i_status.out_free) begin
                        o_cmd.capture = 1'b1;
                        n_state       = i_status.point_last ? ST_END : ST_IDLE;
                    end
                end else begin
                    n_state = i_status.point_last ? ST_END : ST_IDLE;
                end
            end
            ST_END: begin
                if (i_status.cap_zero) begin
                    if (i_status.out_free) begin
                        o_cmd.emit_empty = 1'b1;
                        o_cmd.clr_box    = 1'b1;
                        n_state          = ST_IDLE;
                    end
                end else if (i_status.cap_full) begin
                    o_cmd.clr_box = 1'b1;
                    n_state       = ST_IDLE;
                end else begin
                    o_cmd.fill_start = 1'b1;
                    n_state          = ST_FILL;
                end
            end
            ST_FILL: begin
                if (i_status.out_free) begin
                    o_cmd.fill_adv = 1'b1;
                    if (i_status.fill_end) begin
                        o_cmd.clr_box = 1'b1;
                        n_state       = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_stall = (r_state != ST_IDLE);

endmodule

// ===== rtl/core/rpg3d_datapath.sv =====
`timescale 1ns / 1ps

module rpg3d_datapath #(
    parameter int SAMPLES    = rpg3d_pkg::SAMPLES_DEF,
    parameter int MAX_POINTS = rpg3d_pkg::MAX_POINTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rpg3d_pkg::REG_W-1:0]         i_cfg_index,
    input  logic [rpg3d_pkg::CFG_W-1:0]         i_cfg_data,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_z,
    input  logic                                i_last_point,
    input  logic                                i_out_stall,
    output logic                                o_out_valid,
    output logic [rpg3d_pkg::SLOT_W-1:0]        o_slot,
    output logic [rpg3d_pkg::IDX_W-1:0]         o_source_index,
    output logic [rpg3d_pkg::KIND_W-1:0]        o_kind,
    output logic                                o_last,
    input  rpg3d_pkg::t_cmd                     i_cmd,
    output rpg3d_pkg::t_status                  o_status
);

    localparam int CW    = rpg3d_pkg::COORD_W;
    localparam int LW    = rpg3d_pkg::LEN_W;
    localparam int TW    = rpg3d_pkg::TRIG_W;
    localparam int SW    = rpg3d_pkg::SLOT_W;
    localparam int IW    = rpg3d_pkg::IDX_W;
    localparam int DW    = CW + 1;
    localparam int HW    = CW + 3;
    localparam int PW    = DW + TW;
    localparam int RW    = PW + 1;
    localparam int CNT_W = $clog2(MAX_POINTS);
    localparam int CAP_W = $clog2(SAMPLES + 1);
    localparam int ADR_W = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;

    // configuration
    logic signed [CW-1:0] r_cx, r_by, r_cz;
    logic [LW-1:0]        r_h, r_w, r_l;
    logic signed [TW-1:0] r_ca, r_sa;

    // latched point
    logic signed [CW-1:0] r_px, r_py, r_pz;
    logic                 r_plast;
    logic [CNT_W-1:0]     r_pidx;

    // counters
    logic [CNT_W-1:0] r_pcnt;
    logic [CAP_W-1:0] r_ccnt;
    logic [ADR_W-1:0] r_fslot;
    logic [ADR_W-1:0] r_rd;

    // inside test pipeline
    logic signed [DW-1:0] r_dx, r_dz;
    logic signed [HW-1:0] r_dy2;
    logic                 r_win;
    logic signed [PW-1:0] r_pxc, r_pzs, r_pxs, r_pzc;
    logic                 r_inside;

    // output register
    logic              r_ovalid;
    logic [SW-1:0]     r_oslot;
    logic [IW-1:0]     r_osrc;
    logic [rpg3d_pkg::KIND_W-1:0] r_okind;
    logic              r_olast;

    logic signed [DW-1:0] dx, dz;
    logic signed [HW-1:0] dy2, h_ext;
    logic signed [RW-1:0] xr, zr, l_lim, w_lim;
    logic [CAP_W-1:0]     rd_inc;
    logic [ADR_W-1:0]     rd_next;
    logic [ADR_W-1:0]     raddr;
    logic [CNT_W-1:0]     ram_q;
    logic                 out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_by <= '0;
            r_cz <= '0;
            r_h  <= '0;
            r_w  <= '0;
            r_l  <= '0;
            r_ca <= rpg3d_pkg::COS_RESET;
            r_sa <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rpg3d_pkg::REG_CENTER_X: r_cx <= i_cfg_data[CW-1:0];
                rpg3d_pkg::REG_BOTTOM_Y: r_by <= i_cfg_data[CW-1:0];
                rpg3d_pkg::REG_CENTER_Z: r_cz <= i_cfg_data[CW-1:0];
                rpg3d_pkg::REG_HEIGHT:   r_h  <= i_cfg_data[LW-1:0];
                rpg3d_pkg::REG_WIDTH:    r_w  <= i_cfg_data[LW-1:0];
                rpg3d_pkg::REG_LENGTH:   r_l  <= i_cfg_data[LW-1:0];
                rpg3d_pkg::REG_COS:      r_ca <= i_cfg_data[TW-1:0];
                rpg3d_pkg::REG_SIN:      r_sa <= i_cfg_data[TW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_point) begin
            r_px    <= i_point_x;
            r_py    <= i_point_y;
            r_pz    <= i_point_z;
            r_plast <= i_last_point;
            r_pidx  <= r_pcnt;
        end
    end

    // height check at doubled scale: 2y - 2*bottom + h against h
    assign dx    = $signed({r_px[CW-1], r_px}) - $signed({r_cx[CW-1], r_cx});
    assign dz    = $signed({r_pz[CW-1], r_pz}) - $signed({r_cz[CW-1], r_cz});
    assign h_ext = $signed({4'b0000, r_h});
    assign dy2   = $signed({{2{r_py[CW-1]}}, r_py, 1'b0})
                 - $signed({{2{r_by[CW-1]}}, r_by, 1'b0}) + h_ext;

    // half length and half width at 26 fraction bits
    assign l_lim = $signed({{(RW-LW-13){1'b0}}, r_l, 13'd0});
    assign w_lim = $signed({{(RW-LW-13){1'b0}}, r_w, 13'd0});
    assign xr    = RW'(r_pxc) - RW'(r_pzs);
    assign zr    = RW'(r_pxs) + RW'(r_pzc);

    always_ff @(posedge i_clk) begin
        r_dx   <= dx;
        r_dz   <= dz;
        r_dy2  <= dy2;
        r_win  <= (r_dx <= rpg3d_pkg::WINDOW) && (r_dx >= -rpg3d_pkg::WINDOW)
               && (r_dz <= rpg3d_pkg::WINDOW) && (r_dz >= -rpg3d_pkg::WINDOW)
               && (r_dy2 <= h_ext) && (r_dy2 >= -h_ext);
        r_pxc  <= r_dx * r_ca;
        r_pzs  <= r_dz * r_sa;
        r_pxs  <= r_dx * r_sa;
        r_pzc  <= r_dz * r_ca;
        r_inside <= r_win && (xr <= l_lim) && (xr >= -l_lim)
                 && (zr <= w_lim) && (zr >= -w_lim);
    end

    // fill reads wrap over the captured entries
    assign rd_inc  = CAP_W'(r_rd) + CAP_W'(1);
    assign rd_next = (rd_inc == r_ccnt) ? '0 : rd_inc[ADR_W-1:0];
    assign raddr   = i_cmd.fill_start ? '0 : (i_cmd.fill_adv ? rd_next : r_rd);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pcnt  <= '0;
            r_ccnt  <= '0;
            r_fslot <= '0;
            r_rd    <= '0;
        end else begin
            if (i_cmd.load_point) begin
                r_pcnt <= (r_pcnt == CNT_W'(MAX_POINTS - 1)) ? '0 : r_pcnt + CNT_W'(1);
            end
            if (i_cmd.capture) begin
                r_ccnt <= r_ccnt + CAP_W'(1);
            end
            if (i_cmd.fill_start) begin
                r_fslot <= r_ccnt[ADR_W-1:0];
                r_rd    <= '0;
            end
            if (i_cmd.fill_adv) begin
                r_fslot <= r_fslot + ADR_W'(1);
                r_rd    <= rd_next;
            end
            if (i_cmd.clr_box) begin
                r_pcnt <= '0;
                r_ccnt <= '0;
            end
        end
    end

    rpg3d_ram #(
        .WIDTH (CNT_W),
        .DEPTH (SAMPLES)
    ) u_idx_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.capture),
        .i_waddr (r_ccnt[ADR_W-1:0]),
        .i_wdata (r_pidx),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    assign out_free = !r_ovalid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.capture || i_cmd.emit_empty || i_cmd.fill_adv) begin
            r_ovalid <= 1'b1;
        end else if (!i_out_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_oslot <= SW'(r_ccnt);
            r_osrc  <= IW'(r_pidx);
            r_okind <= rpg3d_pkg::KIND_CAPTURED;
            r_olast <= r_plast && (r_ccnt == CAP_W'(SAMPLES - 1));
        end else if (i_cmd.emit_empty) begin
            r_oslot <= '0;
            r_osrc  <= '0;
            r_okind <= rpg3d_pkg::KIND_EMPTY;
            r_olast <= 1'b1;
        end else if (i_cmd.fill_adv) begin
            r_oslot <= SW'(r_fslot);
            r_osrc  <= IW'(ram_q);
            r_okind <= rpg3d_pkg::KIND_FILL;
            r_olast <= (r_fslot == ADR_W'(SAMPLES - 1));
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_slot         = r_oslot;
    assign o_source_index = r_osrc;
    assign o_kind         = r_okind;
    assign o_last         = r_olast;

    assign o_status.pt_hit     = r_inside;
    assign o_status.cap_full   = (r_ccnt == CAP_W'(SAMPLES));
    assign o_status.cap_zero   = (r_ccnt == '0);
    assign o_status.point_last = r_plast;
    assign o_status.fill_end   = (r_fslot == ADR_W'(SAMPLES - 1));
    assign o_status.out_free   = out_free;

endmodule

// ===== rtl/core/roi_point_gather_3d_unit.sv =====
// flow: a taken point is latched and passes DIFF, MUL, CHK and DEC; DEC
//   captures a hit once the output is free; no new point is taken outside IDLE; the
//   inside test runs through a three-register difference, multiply, compare chain
// a last point goes to END, then one fill beat per unstalled cycle for each free slot
// reset: synchronous active-low, clears counters, state, output valid; cos reg to 1.0
`timescale 1ns / 1ps

module roi_point_gather_3d_unit #(
    parameter int SAMPLES    = rpg3d_pkg::SAMPLES_DEF,
    parameter int MAX_POINTS = rpg3d_pkg::MAX_POINTS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rpg3d_pkg::REG_W-1:0]          i_cfg_index,
    input  logic [rpg3d_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_x,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_y,
    input  logic signed [rpg3d_pkg::COORD_W-1:0] i_point_z,
    input  logic                                 i_last_point,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [rpg3d_pkg::SLOT_W-1:0]         o_slot,
    output logic [rpg3d_pkg::IDX_W-1:0]          o_source_index,
    output logic [rpg3d_pkg::KIND_W-1:0]         o_kind,
    output logic                                 o_last
);

    rpg3d_pkg::t_cmd    cmd;
    rpg3d_pkg::t_status status;

    rpg3d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    rpg3d_datapath #(
        .SAMPLES    (SAMPLES),
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .i_last_point   (i_last_point),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_slot         (o_slot),
        .o_source_index (o_source_index),
        .o_kind         (o_kind),
        .o_last         (o_last),
        .i_cmd          (cmd),
        .o_status       (status)
    );

endmodule

// ===== rtl/core/rpg3d_checker.sv =====
`timescale 1ns / 1ps

module rpg3d_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_in_valid,
    input logic                                 o_in_stall,
    input logic                                 o_out_valid,
    input logic                                 i_out_stall,
    input logic [rpg3d_pkg::SLOT_W-1:0]         o_slot,
    input logic [rpg3d_pkg::IDX_W-1:0]          o_source_index,
    input logic [rpg3d_pkg::KIND_W-1:0]         o_kind,
    input logic                                 o_last
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_slot)
            && $stable(o_source_index) && $stable(o_kind) && $stable(o_last))
        else $error("stalled result beat changed");

    // one point in flight at a time
    a_one_point: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while a point is in flight");

    a_empty_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == rpg3d_pkg::KIND_EMPTY)
            |-> o_last && (o_slot == '0) && (o_source_index == '0))
        else $error("empty box beat malformed");

    // a fill always follows at least one capture
    a_fill_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind == rpg3d_pkg::KIND_FILL) |-> (o_slot != '0))
        else $error("fill beat in slot zero");

endmodule

bind roi_point_gather_3d_unit rpg3d_checker u_rpg3d_checker (.*);
